// ----- rtl/core/pbs_pkg.sv -----
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types and constants for the pixel binning summer: field widths,
// control register indexes and the result beat carried through the output
// queue.
// ----------------------------------------------------------------------------
package pbs_pkg;

   // Field widths fixed by the interface.
   localparam int PIX_W     = 16;
   localparam int SUM_W     = 22;
   localparam int OUT_COL_W = 12;
   localparam int ROW_W     = 12;
   localparam int DIM_W     = 13;
   localparam int BIN_REG_W = 4;

   // Largest bin sum; larger sums saturate here.
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // Largest image height in rows.
   localparam logic [DIM_W-1:0] HEIGHT_MAX = 13'd4096;

   // Control register port.
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_HEIGHT   = 2'd3;

   // Output queue geometry.
   localparam int OUTQ_DEPTH = 3;
   localparam int OUTQ_PTR_W = 2;
   localparam int OUTQ_CNT_W = 2;

   // One result beat.
   typedef struct packed {
      logic [SUM_W-1:0]     bin_sum;
      logic [OUT_COL_W-1:0] bin_column;
      logic [ROW_W-1:0]     bin_row;
      logic                 frame_done;
   } pbs_result_type;

endpackage

// ----- rtl/core/pbs_out_fifo.sv -----
// ----------------------------------------------------------------------------
// pbs_out_fifo
// Three-entry result queue between the accumulate stage and the result
// channel, so the accumulate stage never has to hold while the consumer
// stalls.
// ----------------------------------------------------------------------------
module pbs_out_fifo (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push_valid,
   input  pbs_pkg::pbs_result_type               push_data,
   input  logic                                  pop,
   output logic                                  head_valid,
   output pbs_pkg::pbs_result_type               head_data,
   output logic [pbs_pkg::OUTQ_CNT_W-1:0]        count
);
   import pbs_pkg::*;

   pbs_result_type              entry_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0]       wr_ptr_ff;
   logic [OUTQ_PTR_W-1:0]       wr_ptr_in;
   logic [OUTQ_PTR_W-1:0]       rd_ptr_ff;
   logic [OUTQ_PTR_W-1:0]       rd_ptr_in;
   logic [OUTQ_CNT_W-1:0]       count_ff;
   logic [OUTQ_CNT_W-1:0]       count_in;

   // Pointer and occupancy updates; pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                     : wr_ptr_ff + OUTQ_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                     : rd_ptr_ff + OUTQ_PTR_W'(1);
      end
      priority if (push_valid && !pop) begin
         count_in = count_ff + OUTQ_CNT_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - OUTQ_CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; payload needs no reset.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

`ifndef SYNTHESIS
   // A beat is never written into a full queue unless one is also taken from it.
   assert property (@(posedge clock) disable iff (reset)
      push_valid && !pop |-> count_ff != OUTQ_CNT_W'(OUTQ_DEPTH))
      else $error("pbs_out_fifo: push into full queue");

   // A beat is never taken from an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pbs_out_fifo: pop from empty queue");
`endif

endmodule

// ----- rtl/core/pixel_binning_summer_core.sv -----
// ----------------------------------------------------------------------------
// pixel_binning_summer_core
// Sums bin_width x bin_height blocks of a raster-order pixel stream and emits
// one beat per completed bin, truncating bins at the right and bottom edges.
// ----------------------------------------------------------------------------
// Result path: memory read into the accumulate stage, then the result queue.
// Throughput: 1 pixel per cycle while the result queue has room, set by the
//   read-modify-write of the per-column partial sum memory, with forwarding
//   for back-to-back updates.
// Reset: positions, bin counters, queue and registers clear at once (registers
//   to 4096, 4096, 1, 1); the partial sum memory is not cleared, since each
//   bin's first pixel overwrites its entry.
module pixel_binning_summer_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_BIN    = 8,
   parameter int PIXEL_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [pbs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pbs_pkg::CSR_W-1:0]         csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pbs_pkg::PIX_W-1:0]         req_pixel_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pbs_pkg::SUM_W-1:0]         rsp_bin_sum,
   output logic [pbs_pkg::OUT_COL_W-1:0]     rsp_bin_column,
   output logic [pbs_pkg::ROW_W-1:0]         rsp_bin_row,
   output logic                              rsp_frame_done
);
   import pbs_pkg::*;

   localparam int CPOS_W   = $clog2(MAX_WIDTH);
   localparam int WC_W     = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
   localparam int BIN_W    = $clog2(MAX_BIN + 1);
   localparam int BIDX_W   = $clog2(MAX_BIN);
   localparam int PIX_KEEP = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
   localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << PIX_KEEP) - 64'd1);

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   logic [DIM_W-1:0]     img_w_ff;
   logic [DIM_W-1:0]     img_h_ff;
   logic [BIN_REG_W-1:0] bin_w_ff;
   logic [BIN_REG_W-1:0] bin_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= 13'd4096;
         img_h_ff <= 13'd4096;
         bin_w_ff <= 4'd1;
         bin_h_ff <= 4'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  img_w_ff <= csr_data;
            CSR_IMAGE_HEIGHT: img_h_ff <= csr_data;
            CSR_BIN_WIDTH:    bin_w_ff <= csr_data[BIN_REG_W-1:0];
            CSR_BIN_HEIGHT:   bin_h_ff <= csr_data[BIN_REG_W-1:0];
         endcase
      end
   end

   // Effective geometry: register values clamped to the supported ranges.
   logic [WC_W-1:0]  w_ext;
   logic [WC_W-1:0]  w_cl;
   logic [DIM_W-1:0] h_cl;
   logic [BIN_W-1:0] bw_cl;
   logic [BIN_W-1:0] bh_cl;

   always_comb begin
      w_ext = WC_W'(img_w_ff);
      if (w_ext == '0) begin
         w_cl = WC_W'(1);
      end else if (w_ext > WC_W'(MAX_WIDTH)) begin
         w_cl = WC_W'(MAX_WIDTH);
      end else begin
         w_cl = w_ext;
      end

      if (img_h_ff == '0) begin
         h_cl = DIM_W'(1);
      end else if (img_h_ff > HEIGHT_MAX) begin
         h_cl = HEIGHT_MAX;
      end else begin
         h_cl = img_h_ff;
      end

      if (bin_w_ff == '0) begin
         bw_cl = BIN_W'(1);
      end else if ({1'b0, bin_w_ff} > 5'(MAX_BIN)) begin
         bw_cl = BIN_W'(MAX_BIN);
      end else begin
         bw_cl = BIN_W'(bin_w_ff);
      end

      if (bin_h_ff == '0) begin
         bh_cl = BIN_W'(1);
      end else if ({1'b0, bin_h_ff} > 5'(MAX_BIN)) begin
         bh_cl = BIN_W'(MAX_BIN);
      end else begin
         bh_cl = BIN_W'(bin_h_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Raster position and bin counters
   // ---------------------------------------------------------------------
   logic                 accept;
   logic [CPOS_W-1:0]    col_pos_ff;
   logic [CPOS_W-1:0]    col_pos_in;
   logic [ROW_W-1:0]     row_pos_ff;
   logic [ROW_W-1:0]     row_pos_in;
   logic [BIDX_W-1:0]    cib_ff;
   logic [BIDX_W-1:0]    cib_in;
   logic [BIDX_W-1:0]    rib_ff;
   logic [BIDX_W-1:0]    rib_in;
   logic                 row_end;
   logic                 frame_end;
   logic                 bin_h_end;
   logic                 bin_v_end;

   assign accept = req_valid && !req_stall;

   always_comb begin
      row_end   = (WC_W'(col_pos_ff) + WC_W'(1)) >= w_cl;
      frame_end = ({1'b0, row_pos_ff} + DIM_W'(1)) >= h_cl;
      bin_h_end = ((BIN_W'(cib_ff) + BIN_W'(1)) >= bw_cl) || row_end;
      bin_v_end = ((BIN_W'(rib_ff) + BIN_W'(1)) >= bh_cl) || frame_end;

      if (row_end) begin
         col_pos_in = '0;
         cib_in     = '0;
         rib_in     = bin_v_end ? '0 : rib_ff + BIDX_W'(1);
         row_pos_in = frame_end ? '0 : row_pos_ff + ROW_W'(1);
      end else begin
         col_pos_in = col_pos_ff + CPOS_W'(1);
         cib_in     = bin_h_end ? '0 : cib_ff + BIDX_W'(1);
         rib_in     = rib_ff;
         row_pos_in = row_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         cib_ff     <= '0;
         rib_ff     <= '0;
      end else if (accept) begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         cib_ff     <= cib_in;
         rib_ff     <= rib_in;
      end
   end

   // Quotient banks: for every supported bin size a counter pair tracks the
   // position divided by that size, so the bin index is a plain select even
   // when the bin size changes in mid-frame.
   logic [CPOS_W-1:0] colq_ff [MAX_BIN];
   logic [BIDX_W-1:0] colr_ff [MAX_BIN];
   logic [ROW_W-1:0]  rowq_ff [MAX_BIN];
   logic [BIDX_W-1:0] rowr_ff [MAX_BIN];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BIN; i++) begin
            colq_ff[i] <= '0;
            colr_ff[i] <= '0;
            rowq_ff[i] <= '0;
            rowr_ff[i] <= '0;
         end
      end else if (accept) begin
         for (int i = 0; i < MAX_BIN; i++) begin
            if (row_end) begin
               colq_ff[i] <= '0;
               colr_ff[i] <= '0;
               if (frame_end) begin
                  rowq_ff[i] <= '0;
                  rowr_ff[i] <= '0;
               end else if (rowr_ff[i] == BIDX_W'(i)) begin
                  rowq_ff[i] <= rowq_ff[i] + ROW_W'(1);
                  rowr_ff[i] <= '0;
               end else begin
                  rowr_ff[i] <= rowr_ff[i] + BIDX_W'(1);
               end
            end else if (colr_ff[i] == BIDX_W'(i)) begin
               colq_ff[i] <= colq_ff[i] + CPOS_W'(1);
               colr_ff[i] <= '0;
            end else begin
               colr_ff[i] <= colr_ff[i] + BIDX_W'(1);
            end
         end
      end
   end

   logic [BIDX_W-1:0] bsel_w;
   logic [BIDX_W-1:0] bsel_h;
   logic [CPOS_W-1:0] bin_col;
   logic [ROW_W-1:0]  bin_row;

   assign bsel_w  = BIDX_W'(bw_cl - BIN_W'(1));
   assign bsel_h  = BIDX_W'(bh_cl - BIN_W'(1));
   assign bin_col = colq_ff[bsel_w];
   assign bin_row = rowq_ff[bsel_h];

   // ---------------------------------------------------------------------
   // Accumulate stage: memory data arrives in the cycle after the read
   // ---------------------------------------------------------------------
   logic                 s1_valid_ff;
   logic [CPOS_W-1:0]    s1_addr_ff;
   logic [PIX_W-1:0]     s1_pix_ff;
   logic                 s1_use_ff;
   logic                 s1_emit_ff;
   logic [OUT_COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0]     s1_row_ff;
   logic                 s1_done_ff;
   logic                 s1_fwd_ff;
   logic [SUM_W-1:0]     s1_fwd_sum_ff;
   logic                 s1_fwd_in;
   logic [SUM_W-1:0]     mem_rd_ff;
   logic [SUM_W-1:0]     s1_base;
   logic [SUM_W:0]       s1_sum_wide;
   logic [SUM_W-1:0]     s1_sum;

   // The item in the accumulate stage writes this same edge; the memory
   // read would return the stale value, so its sum is forwarded.
   assign s1_fwd_in = s1_valid_ff && (s1_addr_ff == bin_col);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff    <= bin_col;
         s1_pix_ff     <= req_pixel_value & PIX_MASK;
         s1_use_ff     <= (cib_ff != '0) || (rib_ff != '0);
         s1_emit_ff    <= bin_h_end && bin_v_end;
         s1_col_ff     <= OUT_COL_W'(bin_col);
         s1_row_ff     <= bin_row;
         s1_done_ff    <= row_end && frame_end;
         s1_fwd_ff     <= s1_fwd_in;
         s1_fwd_sum_ff <= s1_sum;
      end
   end

   // Add the pixel to the partial sum, or start a new bin, and saturate.
   always_comb begin
      s1_base     = s1_fwd_ff ? s1_fwd_sum_ff : mem_rd_ff;
      s1_sum_wide = (SUM_W + 1)'(s1_pix_ff) + {1'b0, (s1_use_ff ? s1_base : '0)};
      s1_sum      = (s1_sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : s1_sum_wide[SUM_W-1:0];
   end

   // Partial sum memory, one entry per bin column; read at accept, written
   // back from the accumulate stage.
   logic [SUM_W-1:0] column_sums_mem [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         column_sums_mem[s1_addr_ff] <= s1_sum;
      end
      if (accept) begin
         mem_rd_ff <= column_sums_mem[bin_col];
      end
   end

   // ---------------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------------
   pbs_result_type          push_data;
   pbs_result_type          head_data;
   logic                    push_valid;
   logic                    pop;
   logic [OUTQ_CNT_W-1:0]   outq_count;

   assign push_valid           = s1_valid_ff && s1_emit_ff;
   assign push_data.bin_sum    = s1_sum;
   assign push_data.bin_column = s1_col_ff;
   assign push_data.bin_row    = s1_row_ff;
   assign push_data.frame_done = s1_done_ff;
   assign pop                  = rsp_valid && !rsp_stall;

   pbs_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (rsp_valid),
      .head_data  (head_data),
      .count      (outq_count)
   );

   assign rsp_bin_sum    = head_data.bin_sum;
   assign rsp_bin_column = head_data.bin_column;
   assign rsp_bin_row    = head_data.bin_row;
   assign rsp_frame_done = head_data.frame_done;

   // Take a new pixel only while the queue has room for every beat in flight.
   assign req_stall = ({1'b0, outq_count} + {2'b00, s1_valid_ff})
                      >= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);

`ifndef SYNTHESIS
   // An accepted pixel always reaches the accumulate stage next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("pixel_binning_summer_core: accepted beat lost");

   // Forwarding only ever follows an update in the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_fwd_ff) |-> $past(s1_valid_ff))
      else $error("pixel_binning_summer_core: forward without prior update");

   // The accumulate stage never pushes into a full result queue.
   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> outq_count != OUTQ_CNT_W'(OUTQ_DEPTH))
      else $error("pixel_binning_summer_core: result queue overflow");

   // No result beat is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel_binning_summer_core: result valid after reset");
`endif

endmodule

// ----- test/bin_sum_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bin_sum_checker
// Watches the register port and both beat channels of the pixel binning
// summer. It keeps its own copy of the registers, the raster position and the
// per-column partial sums. From these it works out the bin beat that each
// accepted pixel should complete. Each result beat is checked against the
// oldest bin still awaited.
// ----------------------------------------------------------------------------
module bin_sum_checker
   import pbs_pkg::*;
#(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_BIN   = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [PIX_W-1:0]     req_pixel_value,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [SUM_W-1:0]     rsp_bin_sum,
   input  logic [OUT_COL_W-1:0] rsp_bin_column,
   input  logic [ROW_W-1:0]     rsp_bin_row,
   input  logic                 rsp_frame_done,
   output int                   fail_count,
   output int                   bins_pending
);

   // Shadow of the block's registers and raster state.
   logic [SUM_W-1:0]     partial_sum [MAX_WIDTH];
   int unsigned          column_pos;
   int unsigned          row_pos;
   int unsigned          column_in_bin;
   int unsigned          row_in_bin;
   logic [DIM_W-1:0]     image_width_q;
   logic [DIM_W-1:0]     image_height_q;
   logic [BIN_REG_W-1:0] bin_width_q;
   logic [BIN_REG_W-1:0] bin_height_q;

   // Completed bins still waiting for their beat, oldest first.
   pbs_result_type       awaited_bins [$];
   int                   errors = 0;

   initial begin
      fail_count   = 0;
      bins_pending = 0;
   end

   // Register values outside the meaningful range act as the nearest bound.
   function automatic int unsigned fit(input int unsigned v, input int unsigned lo,
                                       input int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Add one pixel into its bin and record the bin if this pixel closes it.
   task automatic accumulate_pixel(input logic [PIX_W-1:0] pixel);
      int unsigned       w;
      int unsigned       h;
      int unsigned       bw;
      int unsigned       bh;
      int unsigned       bin_col;
      int unsigned       bin_row;
      int unsigned       slot;
      longint unsigned   total;
      bit                row_end;
      bit                frame_end;
      bit                across_done;
      bit                down_done;
      pbs_result_type    beat;
      w  = fit(image_width_q, 1, MAX_WIDTH);
      h  = fit(image_height_q, 1, HEIGHT_MAX);
      bw = fit(bin_width_q, 1, MAX_BIN);
      bh = fit(bin_height_q, 1, MAX_BIN);

      row_end     = (column_pos + 1 >= w);
      frame_end   = (row_pos + 1 >= h);
      across_done = (column_in_bin + 1 >= bw) || row_end;
      down_done   = (row_in_bin + 1 >= bh) || frame_end;

      bin_col = column_pos / bw;
      bin_row = row_pos / bh;
      slot    = bin_col % MAX_WIDTH;

      // The first pixel of a bin starts its partial sum afresh.
      total = pixel;
      if (column_in_bin != 0 || row_in_bin != 0) total += partial_sum[slot];
      if (total > SUM_MAX) total = SUM_MAX;
      partial_sum[slot] = total[SUM_W-1:0];

      if (across_done && down_done) begin
         beat.bin_sum    = total[SUM_W-1:0];
         beat.bin_column = bin_col[OUT_COL_W-1:0];
         beat.bin_row    = bin_row[ROW_W-1:0];
         beat.frame_done = row_end && frame_end;
         awaited_bins.push_back(beat);
      end

      // Advance the raster position.
      if (row_end) begin
         column_pos    = 0;
         column_in_bin = 0;
         row_in_bin    = down_done ? 0 : row_in_bin + 1;
         row_pos       = frame_end ? 0 : row_pos + 1;
      end else begin
         column_pos    = column_pos + 1;
         column_in_bin = across_done ? 0 : column_in_bin + 1;
      end
   endtask

   // Compare one result beat, field by field, with the oldest awaited bin.
   task automatic check_beat();
      pbs_result_type want;
      if (awaited_bins.size() == 0) begin
         $error("result beat with no bin awaited: sum %0d column %0d row %0d",
                rsp_bin_sum, rsp_bin_column, rsp_bin_row);
         errors++;
         return;
      end
      want = awaited_bins.pop_front();
      if (rsp_bin_sum !== want.bin_sum) begin
         $error("bin_sum: expected %0d, actual %0d", want.bin_sum, rsp_bin_sum);
         errors++;
      end
      if (rsp_bin_column !== want.bin_column) begin
         $error("bin_column: expected %0d, actual %0d", want.bin_column, rsp_bin_column);
         errors++;
      end
      if (rsp_bin_row !== want.bin_row) begin
         $error("bin_row: expected %0d, actual %0d", want.bin_row, rsp_bin_row);
         errors++;
      end
      if (rsp_frame_done !== want.frame_done) begin
         $error("frame_done: expected %0d, actual %0d", want.frame_done, rsp_frame_done);
         errors++;
      end
   endtask

   // Sample all channels at the clock edge.
   always @(posedge clock) begin
      if (reset) begin
         column_pos     = 0;
         row_pos        = 0;
         column_in_bin  = 0;
         row_in_bin     = 0;
         image_width_q  = 13'd4096;
         image_height_q = 13'd4096;
         bin_width_q    = 4'd1;
         bin_height_q   = 4'd1;
         awaited_bins.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  image_width_q  = csr_data[DIM_W-1:0];
               CSR_IMAGE_HEIGHT: image_height_q = csr_data[DIM_W-1:0];
               CSR_BIN_WIDTH:    bin_width_q    = csr_data[BIN_REG_W-1:0];
               CSR_BIN_HEIGHT:   bin_height_q   = csr_data[BIN_REG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) accumulate_pixel(req_pixel_value);
         if (rsp_valid && !rsp_stall) check_beat();
      end
      fail_count   <= errors;
      bins_pending <= awaited_bins.size();
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the pixel binning summer with whole frames under a series of image
// and bin geometries: a few hand-picked frames for edge truncation, clamped
// register values and full-scale pixels, then random geometries with random
// pixels, then one wide frame of 8 by 2 bins with a cut right edge. Both sides
// idle in random bursts except in the final frame. The checker beside the
// block does the predicting; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import pbs_pkg::*;

   localparam int MAX_WIDTH      = 4096;
   localparam int MAX_BIN        = 8;
   localparam int RANDOM_PIXELS  = 650;
   localparam int DRAIN_CYCLES   = 4;
   localparam int TAIL_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT = 1000;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 csr_write       = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index       = CSR_IMAGE_WIDTH;
   logic [CSR_W-1:0]     csr_data        = '0;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [SUM_W-1:0]     rsp_bin_sum;
   logic [OUT_COL_W-1:0] rsp_bin_column;
   logic [ROW_W-1:0]     rsp_bin_row;
   logic                 rsp_frame_done;

   int fail_count;
   int bins_pending;
   int pixels_sent     = 0;
   int stall_left      = 0;
   int quiet_cycles    = 0;
   bit calm            = 1'b0;
   bit feed_gaps_on    = 1'b1;
   bit stall_bursts_on = 1'b1;

   // 50 MHz clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   pixel_binning_summer_core #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BIN   (MAX_BIN),
      .PIXEL_BITS(PIX_W)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_value(req_pixel_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bin_sum    (rsp_bin_sum),
      .rsp_bin_column (rsp_bin_column),
      .rsp_bin_row    (rsp_bin_row),
      .rsp_frame_done (rsp_frame_done)
   );

   bin_sum_checker #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_BIN  (MAX_BIN)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_value(req_pixel_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bin_sum    (rsp_bin_sum),
      .rsp_bin_column (rsp_bin_column),
      .rsp_bin_row    (rsp_bin_row),
      .rsp_frame_done (rsp_frame_done),
      .fail_count     (fail_count),
      .bins_pending   (bins_pending)
   );

   // Result side back-pressure in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stall_bursts_on && !calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: ends the run after too long without any beat accepted.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one pixel beat, possibly after an idle burst, and wait for it.
   task automatic send_pixel(input logic [PIX_W-1:0] value);
      int gap;
      if (feed_gaps_on && !calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid       <= 1'b0;
         req_pixel_value <= PIX_W'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   // Stop sending and let every awaited bin come out before touching registers.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bins_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four registers on consecutive cycles; bin registers get noise
   // in the unused upper data bits.
   task automatic set_geometry(input int unsigned w, input int unsigned h,
                               input int unsigned bw, input int unsigned bh);
      csr_write <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_data  <= w[CSR_W-1:0];
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_data  <= h[CSR_W-1:0];
      @(posedge clock);
      csr_index <= CSR_BIN_WIDTH;
      csr_data  <= {(CSR_W-BIN_REG_W)'($urandom), bw[BIN_REG_W-1:0]};
      @(posedge clock);
      csr_index <= CSR_BIN_HEIGHT;
      csr_data  <= {(CSR_W-BIN_REG_W)'($urandom), bh[BIN_REG_W-1:0]};
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Pixels lean toward full scale and zero so that large sums show up.
   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 3))
         0:       return '1;
         1:       return '0;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // Reprogram the geometry and stream whole frames of random pixels.
   task automatic run_frames(input int unsigned w, input int unsigned h,
                             input int unsigned bw, input int unsigned bh,
                             input int frames);
      int unsigned cols;
      int unsigned rows;
      cols = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
      rows = (h == 0) ? 1 : ((h > HEIGHT_MAX) ? HEIGHT_MAX : h);
      settle();
      set_geometry(w, h, bw, bh);
      repeat (frames * cols * rows) send_pixel(random_pixel());
   endtask

   initial begin
      logic [PIX_W-1:0] edge_pattern [15];
      int               random_start;
      int unsigned      w;
      int unsigned      h;
      int unsigned      bw;
      int unsigned      bh;
      edge_pattern = '{16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'hFFFF,
                       16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005,
                       16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Zero registers clamp to one-pixel frames with one-pixel bins.
      settle();
      set_geometry(0, 1, 0, 0);
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      send_pixel(16'h8001);

      // 5x3 image in 2x2 bins: right column and bottom row are cut short.
      settle();
      set_geometry(5, 3, 2, 2);
      foreach (edge_pattern[i]) send_pixel(edge_pattern[i]);

      // Oversized bin registers clamp to 8x8, larger than the 3x2 image.
      settle();
      set_geometry(3, 2, 15, 9);
      repeat (6) send_pixel(16'hFFFF);

      // Random small geometries, with idling switched per phase.
      random_start = pixels_sent;
      while (pixels_sent - random_start < RANDOM_PIXELS) begin
         w  = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 40);
         h  = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
         bw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
         bh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
         feed_gaps_on    = ($urandom_range(0, 3) != 0);
         stall_bursts_on = ($urandom_range(0, 3) != 0);
         run_frames(w, h, bw, bh, $urandom_range(1, 2));
      end

      // One wide frame with a cut right-edge bin, at full rate.
      calm = 1'b1;
      run_frames(300, 2, 8, 2, 1);

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
